// File: rtl/core/rta_pkg.sv
// Shared types, constants and codes for the ring traffic automaton.
package rta_pkg;

  localparam int CELLS_DEF  = 128;
  localparam int OPC_W      = 2;
  localparam int IDX_W      = 7;
  localparam int DLY_W      = 3;
  localparam int MOVED_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int GROUP      = 8;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUICK_START  = 2'd1;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_CLEAR_GO,
    CMD_RELAX,
    CMD_COMMIT,
    CMD_RELOAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic             qs;
    logic             occ;
    logic [DLY_W-1:0] delay;
  } cell_ctrl_t;

  typedef struct packed {
    logic             car;
    logic             go;
    logic             go_calc;
    logic             fill;
    logic             moved;
    logic [DLY_W-1:0] delay;
    logic [DLY_W-1:0] cd;
  } cell_view_t;

  typedef struct packed {
    logic               cell_occupied;
    logic               cell_moved;
    logic [DLY_W-1:0]   cell_countdown;
    logic [DLY_W-1:0]   cell_delay;
    logic [MOVED_W-1:0] moved_cars;
    logic               crossed_boundary;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELAX,
    ST_COUNT,
    ST_DELIVER
  } state_t;

endpackage

// File: rtl/core/rta_item_if.sv
// Input item channel: valid/ready with one cell operation.
interface rta_item_if;
  logic                           valid;
  logic                           ready;
  logic [rta_pkg::OPC_W-1:0]      opcode;
  logic [rta_pkg::IDX_W-1:0]      cell_index;
  logic                           occupied;
  logic [rta_pkg::DLY_W-1:0]      delay_class;

  modport source (output valid, opcode, cell_index, occupied, delay_class, input ready);
  modport sink   (input valid, opcode, cell_index, occupied, delay_class, output ready);
endinterface

// File: rtl/core/rta_result_if.sv
// Result channel: valid/ready with one result item.
interface rta_result_if;
  logic                            valid;
  logic                            ready;
  logic                            cell_occupied;
  logic                            cell_moved;
  logic [rta_pkg::DLY_W-1:0]       cell_countdown;
  logic [rta_pkg::DLY_W-1:0]       cell_delay;
  logic [rta_pkg::MOVED_W-1:0]     moved_cars;
  logic                            crossed_boundary;

  modport source (output valid, cell_occupied, cell_moved, cell_countdown, cell_delay,
                  moved_cars, crossed_boundary, input ready);
  modport sink   (input valid, cell_occupied, cell_moved, cell_countdown, cell_delay,
                  moved_cars, crossed_boundary, output ready);
endinterface

// File: rtl/core/rta_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
interface rta_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rta_pkg::CFG_IDX_W-1:0]     index;
  logic [rta_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rta_cell.sv
// One ring cell: car state, move decision and hand-over to the next cell.
module rta_cell #(
  parameter int CW    = 8,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  rta_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       ring_n,
  input  logic [CW-1:0]       wr_idx,
  input  rta_pkg::cell_view_t nbr,
  input  rta_pkg::cell_view_t head,
  input  rta_pkg::cell_view_t bhd,
  output rta_pkg::cell_view_t view
);

  localparam logic [rta_pkg::DLY_W-1:0] DLY_ONE = rta_pkg::DLY_W'(1);

  logic                      car;
  logic                      go;
  logic                      moved;
  logic [rta_pkg::DLY_W-1:0] delay;
  logic [rta_pkg::DLY_W-1:0] cd;

  logic                in_use;
  logic                is_last;
  logic                may;
  logic                go_calc;
  rta_pkg::cell_view_t ahead;

  always_comb begin
    in_use  = CW'(INDEX) < ring_n;
    is_last = CW'(INDEX) == (ring_n - CW'(1));
    ahead   = is_last ? head : nbr;
    may     = !ahead.car || (ctrl.qs && ahead.go);
    go_calc = in_use && car && (cd == '0) && may;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      car   <= 1'b0;
      go    <= 1'b0;
      moved <= 1'b0;
      delay <= '0;
      cd    <= '0;
    end else begin
      unique case (ctrl.cmd)
        rta_pkg::CMD_HOLD: ;
        rta_pkg::CMD_WRITE: begin
          if (CW'(INDEX) == wr_idx) begin
            car   <= ctrl.occ;
            delay <= ctrl.occ ? ctrl.delay : '0;
            cd    <= ctrl.occ ? ctrl.delay : '0;
            moved <= 1'b0;
          end
        end
        rta_pkg::CMD_CLEAR_GO: go <= 1'b0;
        rta_pkg::CMD_RELAX:    go <= go_calc;
        rta_pkg::CMD_COMMIT: begin
          if (in_use) begin
            if (car && !go) begin
              // staying car: may here implies a non-zero countdown
              moved <= 1'b0;
              cd    <= may ? cd - DLY_ONE : delay;
            end else if (bhd.go) begin
              car   <= 1'b1;
              delay <= bhd.delay;
              cd    <= bhd.cd;
              moved <= 1'b1;
            end else begin
              car   <= 1'b0;
              delay <= '0;
              cd    <= '0;
              moved <= 1'b0;
            end
          end
        end
        rta_pkg::CMD_RELOAD: begin
          if (in_use) begin
            cd    <= delay;
            moved <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign view.car     = car;
  assign view.go      = go;
  assign view.go_calc = go_calc;
  assign view.fill    = car || !in_use;
  assign view.moved   = moved;
  assign view.delay   = delay;
  assign view.cd      = cd;

endmodule

// File: rtl/core/rta_tally.sv
// Counts set move flags, one group of cells per cycle.
module rta_tally #(
  parameter int CELLS = rta_pkg::CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [CELLS-1:0]           bits,
  output logic                       done,
  output logic [$clog2(CELLS+1)-1:0] total
);

  localparam int G  = (CELLS + rta_pkg::GROUP - 1) / rta_pkg::GROUP;
  localparam int GW = (G > 1) ? $clog2(G) : 1;
  localparam int AW = $clog2(CELLS + 1);
  localparam int PW = $clog2(rta_pkg::GROUP + 1);

  logic                          busy;
  logic [GW-1:0]                 grp;
  logic [AW-1:0]                 acc;
  logic [G*rta_pkg::GROUP-1:0]   padded;
  logic [rta_pkg::GROUP-1:0]     slice;
  logic [PW-1:0]                 pop;
  logic                          last;

  always_comb begin
    padded = (G*rta_pkg::GROUP)'(bits);
    slice  = padded[grp*rta_pkg::GROUP +: rta_pkg::GROUP];
    pop    = '0;
    for (int b = 0; b < rta_pkg::GROUP; b++) begin
      pop = pop + PW'(slice[b]);
    end
    last = grp == GW'(G - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      grp  <= '0;
      acc  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        grp  <= '0;
        acc  <= '0;
      end else if (busy) begin
        acc <= acc + AW'(pop);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          grp <= grp + GW'(1);
        end
      end
    end
  end

  assign total = acc;

endmodule

// File: rtl/core/ring_traffic_automaton_step.sv
// Ring traffic automaton: a chain of cells resolving one tick of rule-184 traffic.
// Write, read, unused and full-ring tick: the answer goes into res, then into the
// result register. Tick: clear go, relax until no go flag changes, commit, tally go
// flags a group at a time, deliver; the relaxation grows with runs of following movers.
// One item in work at a time; the next input transfer is taken while a result waits.
// Synchronous reset empties the road, sets cells_in_use to 128 and quick_start to 1.
module ring_traffic_automaton_step #(
  parameter int CELLS = rta_pkg::CELLS_DEF
) (
  input logic          clk,
  input logic          rst,
  rta_item_if.sink     items,
  rta_result_if.source results,
  rta_cfg_if.sink      cfg
);

  localparam int CW = ($clog2(CELLS + 1) > 8) ? $clog2(CELLS + 1) : 8;
  localparam int IW = $clog2(CELLS);
  localparam int AW = $clog2(CELLS + 1);

  logic [rta_pkg::CFG_DATA_W-1:0] cells_in_use;
  logic                           quick_start;

  rta_pkg::state_t  state, state_next;
  rta_pkg::result_t res, res_next;
  rta_pkg::result_t out_data;
  logic             out_valid;
  logic             out_load;

  rta_pkg::cell_ctrl_t ctrl;
  rta_pkg::cell_view_t v [CELLS];
  rta_pkg::cell_view_t tail;
  rta_pkg::cell_view_t rd;

  logic [CELLS-1:0] go_vec;
  logic [CELLS-1:0] chg_vec;
  logic [CELLS-1:0] fill_vec;

  logic [CW-1:0] cu_ext;
  logic [CW-1:0] ring_n;
  logic [CW-1:0] tail_idx;
  logic [CW-1:0] idx_ext;
  logic          idx_ok;
  logic          changed;
  logic          full;
  logic          tally_start;
  logic          tally_done;
  logic [AW-1:0] tally_total;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_use <= rta_pkg::CFG_DATA_W'(rta_pkg::CELLS_DEF);
      quick_start  <= 1'b1;
    end else if (cfg.valid) begin
      if (cfg.index == rta_pkg::CFG_CELLS_IN_USE) begin
        cells_in_use <= cfg.data;
      end else if (cfg.index == rta_pkg::CFG_QUICK_START) begin
        quick_start <= cfg.data[0];
      end
    end
  end

  always_comb begin
    cu_ext = CW'(cells_in_use);
    if (cu_ext < CW'(3)) begin
      ring_n = CW'(3);
    end else if (cu_ext > CW'(CELLS)) begin
      ring_n = CW'(CELLS);
    end else begin
      ring_n = cu_ext;
    end
    tail_idx = ring_n - CW'(1);
    idx_ext  = CW'(items.cell_index);
    idx_ok   = idx_ext < ring_n;
    tail     = v[tail_idx[IW-1:0]];
    rd       = v[idx_ext[IW-1:0]];
    changed  = |chg_vec;
    full     = &fill_vec;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    rta_pkg::cell_view_t bhd_v;
    if (i == 0) begin : g_head
      assign bhd_v = tail;
    end else begin : g_body
      assign bhd_v = v[i-1];
    end

    rta_cell #(
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .ring_n (ring_n),
      .wr_idx (idx_ext),
      .nbr    (v[(i + 1) % CELLS]),
      .head   (v[0]),
      .bhd    (bhd_v),
      .view   (v[i])
    );

    assign go_vec[i]   = v[i].go;
    assign chg_vec[i]  = v[i].go ^ v[i].go_calc;
    assign fill_vec[i] = v[i].fill;
  end

  rta_tally #(
    .CELLS (CELLS)
  ) u_tally (
    .clk   (clk),
    .rst   (rst),
    .start (tally_start),
    .bits  (go_vec),
    .done  (tally_done),
    .total (tally_total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_comb begin
    state_next  = state;
    res_next    = res;
    items.ready = 1'b0;
    tally_start = 1'b0;
    out_load    = 1'b0;
    ctrl.cmd    = rta_pkg::CMD_HOLD;
    ctrl.qs     = quick_start;
    ctrl.occ    = items.occupied;
    ctrl.delay  = items.delay_class;

    unique case (state)
      rta_pkg::ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          res_next   = '0;
          state_next = rta_pkg::ST_DELIVER;
          unique case (rta_pkg::op_t'(items.opcode))
            rta_pkg::OP_WRITE: begin
              if (idx_ok) begin
                ctrl.cmd = rta_pkg::CMD_WRITE;
              end
            end
            rta_pkg::OP_READ: begin
              if (idx_ok) begin
                res_next.cell_occupied  = rd.car;
                res_next.cell_moved     = rd.moved;
                res_next.cell_countdown = rd.cd;
                res_next.cell_delay     = rd.delay;
              end
            end
            rta_pkg::OP_TICK: begin
              if (full) begin
                ctrl.cmd = rta_pkg::CMD_RELOAD;
              end else begin
                ctrl.cmd   = rta_pkg::CMD_CLEAR_GO;
                state_next = rta_pkg::ST_RELAX;
              end
            end
            default: ;
          endcase
        end
      end
      rta_pkg::ST_RELAX: begin
        if (changed) begin
          ctrl.cmd = rta_pkg::CMD_RELAX;
        end else begin
          ctrl.cmd                  = rta_pkg::CMD_COMMIT;
          res_next.crossed_boundary = tail.go;
          tally_start               = 1'b1;
          state_next                = rta_pkg::ST_COUNT;
        end
      end
      rta_pkg::ST_COUNT: begin
        if (tally_done) begin
          res_next.moved_cars = rta_pkg::MOVED_W'(tally_total);
          state_next          = rta_pkg::ST_DELIVER;
        end
      end
      rta_pkg::ST_DELIVER: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = rta_pkg::ST_IDLE;
        end
      end
      default: state_next = rta_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  assign results.valid            = out_valid;
  assign results.cell_occupied    = out_data.cell_occupied;
  assign results.cell_moved       = out_data.cell_moved;
  assign results.cell_countdown   = out_data.cell_countdown;
  assign results.cell_delay       = out_data.cell_delay;
  assign results.moved_cars       = out_data.moved_cars;
  assign results.crossed_boundary = out_data.crossed_boundary;

endmodule

// File: verif/ring_traffic_automaton_step_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ring traffic automaton: scoreboard, stimulus and checks.
module ring_traffic_automaton_step_test;

  localparam int CELLS = rta_pkg::CELLS_DEF;
  localparam logic [rta_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS = 450;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [rta_pkg::OPC_W-1:0] opcode;
    logic [rta_pkg::IDX_W-1:0] cell_index;
    logic                      occupied;
    logic [rta_pkg::DLY_W-1:0] delay_class;
  } road_item_t;

  class road_scoreboard;
    bit                      car     [CELLS];
    bit [rta_pkg::DLY_W-1:0] delay   [CELLS];
    bit [rta_pkg::DLY_W-1:0] countdn [CELLS];
    bit                      moved   [CELLS];
    bit [7:0]                cells_in_use;
    bit                      quick_start;
    rta_pkg::result_t        answers_due[$];
    int                      errors, ticks, jammed_ticks, cars_moved, crossings;

    function new();
      cells_in_use = 8'd128;
      quick_start  = 1'b1;
      foreach (car[i]) begin
        car[i]     = 1'b0;
        delay[i]   = '0;
        countdn[i] = '0;
        moved[i]   = 1'b0;
      end
    endfunction

    function void write_reg(logic [rta_pkg::CFG_IDX_W-1:0] index,
                            logic [rta_pkg::CFG_DATA_W-1:0] data);
      if (index == rta_pkg::CFG_CELLS_IN_USE) cells_in_use = data;
      else if (index == rta_pkg::CFG_QUICK_START) quick_start = data[0];
    endfunction

    function int ring_span();
      if (cells_in_use < 3) return 3;
      if (cells_in_use > CELLS) return CELLS;
      return cells_in_use;
    endfunction

    // one tick: decide leaders before followers, then shift the movers
    function void step_road(output logic [rta_pkg::MOVED_W-1:0] moved_cnt,
                            output logic crossed);
      int n, e, c, a, d, total;
      bit                      go      [CELLS];
      bit                      car_n   [CELLS];
      bit [rta_pkg::DLY_W-1:0] delay_n [CELLS];
      bit [rta_pkg::DLY_W-1:0] cd_n    [CELLS];
      bit                      moved_n [CELLS];
      n = ring_span();
      e = n;
      total = 0;
      crossed = 1'b0;
      moved_cnt = '0;
      ticks++;
      for (int i = 0; i < n; i++) if (!car[i]) e = i;
      if (e == n) begin
        jammed_ticks++;
        for (int i = 0; i < n; i++) begin
          countdn[i] = delay[i];
          moved[i]   = 1'b0;
        end
        return;
      end
      foreach (go[i]) begin
        go[i] = 1'b0;
        car_n[i] = 1'b0;
        delay_n[i] = '0;
        cd_n[i] = '0;
        moved_n[i] = 1'b0;
      end
      for (int k = 1; k < n; k++) begin
        c = (e + n - k) % n;
        a = (c + 1) % n;
        if (car[c]) begin
          if (!car[a] || (quick_start && go[a])) begin
            if (countdn[c] == 0) go[c] = 1'b1;
            else countdn[c] = countdn[c] - 1'b1;
          end else begin
            countdn[c] = delay[c];
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        if (car[i]) begin
          d = go[i] ? (i + 1) % n : i;
          car_n[d]   = 1'b1;
          delay_n[d] = delay[i];
          cd_n[d]    = countdn[i];
          moved_n[d] = go[i];
          if (go[i]) begin
            total++;
            if (i == n - 1) begin
              crossed = 1'b1;
              crossings++;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        car[i]     = car_n[i];
        delay[i]   = delay_n[i];
        countdn[i] = cd_n[i];
        moved[i]   = moved_n[i];
      end
      cars_moved += total;
      moved_cnt = total[rta_pkg::MOVED_W-1:0];
    endfunction

    function void note_item(road_item_t it);
      rta_pkg::result_t r;
      int n;
      r = '0;
      n = ring_span();
      case (it.opcode)
        rta_pkg::OP_WRITE: begin
          if (it.cell_index < n) begin
            car[it.cell_index]     = it.occupied;
            delay[it.cell_index]   = it.occupied ? it.delay_class : '0;
            countdn[it.cell_index] = it.occupied ? it.delay_class : '0;
            moved[it.cell_index]   = 1'b0;
          end
        end
        rta_pkg::OP_TICK: step_road(r.moved_cars, r.crossed_boundary);
        rta_pkg::OP_READ: begin
          if (it.cell_index < n) begin
            r.cell_occupied  = car[it.cell_index];
            r.cell_moved     = moved[it.cell_index];
            r.cell_countdown = countdn[it.cell_index];
            r.cell_delay     = delay[it.cell_index];
          end
        end
        default: ;
      endcase
      answers_due.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_answer(rta_pkg::result_t got);
      rta_pkg::result_t want;
      if (answers_due.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
        return;
      end
      want = answers_due.pop_front();
      compare("cell_occupied", want.cell_occupied, got.cell_occupied);
      compare("cell_moved", want.cell_moved, got.cell_moved);
      compare("cell_countdown", want.cell_countdown, got.cell_countdown);
      compare("cell_delay", want.cell_delay, got.cell_delay);
      compare("moved_cars", want.moved_cars, got.moved_cars);
      compare("crossed_boundary", want.crossed_boundary, got.crossed_boundary);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   items_fed = 0;
  int   stall_left = 0;
  bit   idle_on = 1'b0;
  bit   calm = 1'b0;
  road_scoreboard sb;

  rta_item_if   items();
  rta_result_if results();
  rta_cfg_if    cfg();

  ring_traffic_automaton_step #(.CELLS(CELLS)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.answers_due.size());
      $display("ring_traffic_automaton_step_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : answer_side
    rta_pkg::result_t seen;
    if (!rst && results.valid && results.ready) begin
      seen.cell_occupied    = results.cell_occupied;
      seen.cell_moved       = results.cell_moved;
      seen.cell_countdown   = results.cell_countdown;
      seen.cell_delay       = results.cell_delay;
      seen.moved_cars       = results.moved_cars;
      seen.crossed_boundary = results.crossed_boundary;
      sb.check_answer(seen);
    end
    if (stall_left > 0) begin
      stall_left--;
      results.ready <= 1'b0;
    end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  function automatic road_item_t road_op(logic [rta_pkg::OPC_W-1:0] op, int idx, bit occ,
                                         int dly);
    road_op.opcode      = op;
    road_op.cell_index  = idx[rta_pkg::IDX_W-1:0];
    road_op.occupied    = occ;
    road_op.delay_class = dly[rta_pkg::DLY_W-1:0];
  endfunction

  task automatic send_item(input road_item_t it);
    items.valid       <= 1'b1;
    items.opcode      <= it.opcode;
    items.cell_index  <= it.cell_index;
    items.occupied    <= it.occupied;
    items.delay_class <= it.delay_class;
    do @(posedge clk); while (!items.ready);
    if (!(it.opcode == OP_UNUSED ||
          (it.opcode == rta_pkg::OP_WRITE && it.cell_index >= sb.ring_span())))
      items_fed++;
    sb.note_item(it);
    calm = (items_fed > ITEMS - 60);
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [rta_pkg::CFG_IDX_W-1:0] index,
                           input logic [rta_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(index, data);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // every item answers once, so an empty queue means the block is idle
  task automatic drain_road();
    items.valid <= 1'b0;
    @(posedge clk);
    while (sb.answers_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input int phase);
    int size, n, density, pick;
    drain_road();
    case ($urandom_range(0, 9))
      0:       size = $urandom_range(0, 2);
      1:       size = $urandom_range(129, 255);
      2, 3:    size = 128;
      default: size = $urandom_range(3, 20);
    endcase
    if (phase == 0) size = 0;
    if (phase == 1) size = 255;
    write_reg(rta_pkg::CFG_CELLS_IN_USE, size[7:0]);
    write_reg(rta_pkg::CFG_QUICK_START, 8'($urandom));
    idle_on = ($urandom_range(0, 2) != 0);
    n = sb.ring_span();
    density = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(20, 85);
    if (n <= 24) begin
      for (int i = 0; i < n; i++)
        send_item(road_op(rta_pkg::OP_WRITE, i, $urandom_range(1, 100) <= density,
                          $urandom_range(0, 7)));
    end else begin
      repeat (24)
        send_item(road_op(rta_pkg::OP_WRITE, $urandom_range(0, n - 1),
                          $urandom_range(1, 100) <= density, $urandom_range(0, 7)));
    end
    repeat ($urandom_range(15, 35)) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_item(road_op(rta_pkg::OP_TICK, $urandom_range(0, 127), $urandom_range(0, 1),
                          $urandom_range(0, 7)));
      else if (pick < 70)
        send_item(road_op(rta_pkg::OP_READ,
                          ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, n - 1),
                          $urandom_range(0, 1), $urandom_range(0, 7)));
      else if (pick < 88)
        send_item(road_op(rta_pkg::OP_WRITE, $urandom_range(0, n - 1),
                          $urandom_range(1, 100) <= density, $urandom_range(0, 7)));
      else if (pick < 94)
        send_item(road_op(rta_pkg::OP_WRITE, $urandom_range(0, 127), $urandom_range(0, 1),
                          $urandom_range(0, 7)));
      else
        send_item(road_op(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 1),
                          $urandom_range(0, 7)));
    end
  endtask

  initial begin
    int phase;
    items.valid       = 1'b0;
    items.opcode      = rta_pkg::OP_WRITE;
    items.cell_index  = '0;
    items.occupied    = 1'b0;
    items.delay_class = '0;
    results.ready     = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = rta_pkg::CFG_CELLS_IN_USE;
    cfg.data          = '0;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty road, a leader pulling a follower while a delayed car waits at the last cell, unused opcode, clearing write
    send_item(road_op(rta_pkg::OP_READ, 0, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_READ, 127, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_WRITE, 127, 1'b1, 7));
    send_item(road_op(rta_pkg::OP_WRITE, 0, 1'b1, 0));
    send_item(road_op(rta_pkg::OP_WRITE, 1, 1'b1, 0));
    send_item(road_op(rta_pkg::OP_TICK, 0, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_READ, 1, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_READ, 127, 1'b0, 0));
    send_item(road_op(OP_UNUSED, 127, 1'b1, 7));
    send_item(road_op(rta_pkg::OP_WRITE, 127, 1'b0, 7));
    send_item(road_op(rta_pkg::OP_READ, 127, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_TICK, 127, 1'b1, 7));
    drain_road();

    // smallest ring, full then opened, strict following
    write_reg(rta_pkg::CFG_CELLS_IN_USE, 8'd3);
    write_reg(rta_pkg::CFG_QUICK_START, 8'd0);
    send_item(road_op(rta_pkg::OP_WRITE, 0, 1'b1, 1));
    send_item(road_op(rta_pkg::OP_WRITE, 1, 1'b1, 2));
    send_item(road_op(rta_pkg::OP_WRITE, 2, 1'b1, 5));
    send_item(road_op(rta_pkg::OP_TICK, 0, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_READ, 2, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_WRITE, 5, 1'b1, 3));
    send_item(road_op(rta_pkg::OP_READ, 5, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_WRITE, 2, 1'b0, 0));
    repeat (3) send_item(road_op(rta_pkg::OP_TICK, 0, 1'b0, 0));
    send_item(road_op(rta_pkg::OP_READ, 2, 1'b0, 0));

    phase = 0;
    while (items_fed < ITEMS) begin
      run_phase(phase);
      phase++;
    end

    drain_road();
    repeat (200) @(posedge clk);
    $display("%0d items over %0d ring settings; %0d ticks, %0d of them on a full ring",
             items_fed, phase + 2, sb.ticks, sb.jammed_ticks);
    $display("%0d car moves, %0d wraps from the last cell to cell zero",
             sb.cars_moved, sb.crossings);
    if (sb.errors == 0 && sb.answers_due.size() == 0) begin
      $display("ring_traffic_automaton_step_test: PASS");
    end else begin
      if (sb.answers_due.size() != 0)
        $error("%0d results never arrived", sb.answers_due.size());
      $display("ring_traffic_automaton_step_test: FAIL");
    end
    $finish;
  end
endmodule
